### rtl/assert_macros.svh
// Assertion macros shared by the parser RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked on every rising clock edge outside reset.
`define PWP_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Condition that must never hold outside reset.
`define PWP_NEVER(label, cond, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);

`endif

### rtl/pwp_pkg.sv
// Types and constants for the protobuf wire parser.
`default_nettype none

package pwp_pkg;

  localparam int LEN_BITS         = 32;
  localparam int MAX_VARINT_BYTES = 10;
  localparam int FIXED64_BYTES    = 8;
  localparam int FIXED32_BYTES    = 4;

  localparam logic [2:0] WT_VARINT  = 3'd0;
  localparam logic [2:0] WT_FIXED64 = 3'd1;
  localparam logic [2:0] WT_LEN     = 3'd2;
  localparam logic [2:0] WT_FIXED32 = 3'd5;

  typedef enum logic [2:0] {
    PH_KEY     = 3'd0,
    PH_VARINT  = 3'd1,
    PH_FIXED64 = 3'd2,
    PH_LENGTH  = 3'd3,
    PH_PAYLOAD = 3'd4,
    PH_FIXED32 = 3'd5
  } phase_t;

  typedef enum logic [2:0] {
    K_VARINT  = 3'd0,
    K_FIXED64 = 3'd1,
    K_LEN_HDR = 3'd2,
    K_PAYLOAD = 3'd3,
    K_FIXED32 = 3'd4,
    K_ERROR   = 3'd5,
    K_END     = 3'd6
  } kind_t;

  typedef enum logic [2:0] {
    E_NONE      = 3'd0,
    E_TOO_LONG  = 3'd1,
    E_WIRE_TYPE = 3'd2,
    E_TRUNCATED = 3'd3,
    E_LEN_LARGE = 3'd4
  } err_t;

  typedef struct packed {
    logic       operation;
    logic [7:0] data_byte;
  } in_word_t;

  typedef struct packed {
    kind_t       kind;
    logic [31:0] field_id;
    logic [2:0]  wtype;
    logic [63:0] value;
    logic [7:0]  payload_byte;
    logic        payload_last;
    err_t        error_code;
  } out_word_t;

endpackage

`default_nettype wire

### rtl/protobuf_wire_parser.sv
// Streaming protobuf wire-format parser, one message byte per word.
//
//   channel  | direction | handshake        | word
//   in_      | input     | in_valid/stall   | in_word_t  (byte or end mark)
//   out_     | output    | out_valid/stall  | out_word_t (decoded field)
//   cfg_     | input     | cfg_valid/ready  | emit_payload bit
//
// One input word per cycle while in_stall is low; a taken word's result is
// registered in the output stage. The parse state is updated in a single pass per byte.
// A two-entry output stage (result register plus skid) lets input keep
// flowing while a result waits; in_stall rises only when the skid is full.
// rst_n is synchronous; it empties the output stage and sets emit_payload.
// An end-of-message word always returns the parser to its idle state.
`default_nettype none
`include "assert_macros.svh"

module protobuf_wire_parser import pwp_pkg::*; (
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire logic      in_valid,
  output logic           in_stall,
  input  wire in_word_t  in_data,
  output logic           out_valid,
  input  wire logic      out_stall,
  output out_word_t      out_data,
  input  wire logic      cfg_valid,
  output logic           cfg_ready,
  input  wire logic      cfg_data
);

  // parse state
  phase_t              phase_r,  phase_nxt;
  logic [63:0]         acc_r,    acc_nxt;
  logic [3:0]          idx_r,    idx_nxt;
  logic [31:0]         field_r,  field_nxt;
  logic [2:0]          wt_r,     wt_nxt;
  logic [LEN_BITS-1:0] bl_r,     bl_nxt;
  logic                err_r,    err_nxt;
  logic                emit_r;

  // output stage
  logic      out_valid_r, skid_valid_r;
  out_word_t out_r, skid_r;

  logic      res_valid;
  out_word_t res;

  logic                in_acc, out_take, is_end;
  logic [7:0]          b;
  logic [6:0]          sh7;
  logic [5:0]          sh8;
  logic [63:0]         vacc, f64acc;
  logic [3:0]          idx_inc;
  logic                cont, too_long, wt_known, len_big;
  logic [31:0]         key_field;
  logic [2:0]          key_wt;
  logic [LEN_BITS-1:0] bl_dec;

  assign in_stall  = skid_valid_r;
  assign in_acc    = in_valid && !skid_valid_r;
  assign out_valid = out_valid_r;
  assign out_data  = out_r;
  assign out_take  = out_valid_r && !out_stall;
  assign cfg_ready = 1'b1;

  assign is_end = in_data.operation;
  assign b      = in_data.data_byte;

  // 7 * index for varint groups, 8 * index for fixed64 bytes
  assign sh7     = {idx_r, 3'b000} - {3'b000, idx_r};
  assign sh8     = {idx_r[2:0], 3'b000};
  assign vacc    = acc_r | ({57'd0, b[6:0]} << sh7);
  assign f64acc  = acc_r | ({56'd0, b} << sh8);
  assign idx_inc = idx_r + 4'd1;
  assign cont     = b[7];
  assign too_long = cont && (idx_inc >= 4'(MAX_VARINT_BYTES));

  assign key_field = vacc[34:3];
  assign key_wt    = vacc[2:0];
  assign wt_known  = (key_wt == WT_VARINT) || (key_wt == WT_FIXED64) ||
                     (key_wt == WT_LEN) || (key_wt == WT_FIXED32);
  assign len_big   = (vacc >> LEN_BITS) != 64'd0;
  assign bl_dec    = (bl_r != '0) ? bl_r - LEN_BITS'(1) : bl_r;

  // next parse state
  always_comb begin
    phase_nxt = phase_r;
    acc_nxt   = acc_r;
    idx_nxt   = idx_r;
    field_nxt = field_r;
    wt_nxt    = wt_r;
    bl_nxt    = bl_r;
    err_nxt   = err_r;
    if (in_acc) begin
      if (is_end) begin
        phase_nxt = PH_KEY;
        acc_nxt   = '0;
        idx_nxt   = '0;
        bl_nxt    = '0;
        field_nxt = '0;
        wt_nxt    = '0;
        err_nxt   = 1'b0;
      end else if (!err_r) begin
        case (phase_r)
          PH_KEY, PH_VARINT, PH_LENGTH: begin
            if (cont) begin
              if (too_long) begin
                err_nxt   = 1'b1;
                phase_nxt = PH_KEY;
                acc_nxt   = '0;
                idx_nxt   = '0;
                bl_nxt    = '0;
              end else begin
                acc_nxt = vacc;
                idx_nxt = idx_inc;
              end
            end else begin
              acc_nxt = '0;
              idx_nxt = '0;
              if (phase_r == PH_KEY) begin
                field_nxt = key_field;
                wt_nxt    = key_wt;
                case (key_wt)
                  WT_VARINT:  phase_nxt = PH_VARINT;
                  WT_FIXED64: phase_nxt = PH_FIXED64;
                  WT_LEN:     phase_nxt = PH_LENGTH;
                  WT_FIXED32: phase_nxt = PH_FIXED32;
                  default: begin
                    err_nxt = 1'b1;
                    bl_nxt  = '0;
                  end
                endcase
              end else if (phase_r == PH_VARINT) begin
                phase_nxt = PH_KEY;
              end else if (len_big) begin
                err_nxt   = 1'b1;
                phase_nxt = PH_KEY;
                bl_nxt    = '0;
              end else begin
                bl_nxt    = vacc[LEN_BITS-1:0];
                phase_nxt = (vacc == 64'd0) ? PH_KEY : PH_PAYLOAD;
              end
            end
          end
          PH_FIXED64: begin
            if (idx_inc >= 4'(FIXED64_BYTES)) begin
              phase_nxt = PH_KEY;
              acc_nxt   = '0;
              idx_nxt   = '0;
              bl_nxt    = '0;
            end else begin
              acc_nxt = f64acc;
              idx_nxt = idx_inc;
            end
          end
          PH_FIXED32: begin
            if (idx_inc >= 4'(FIXED32_BYTES)) begin
              phase_nxt = PH_KEY;
              acc_nxt   = '0;
              idx_nxt   = '0;
              bl_nxt    = '0;
            end else begin
              idx_nxt = idx_inc;
            end
          end
          PH_PAYLOAD: begin
            bl_nxt = bl_dec;
            if (bl_dec == '0) begin
              phase_nxt = PH_KEY;
              acc_nxt   = '0;
              idx_nxt   = '0;
            end
          end
          default: begin
            phase_nxt = PH_KEY;
            acc_nxt   = '0;
            idx_nxt   = '0;
            bl_nxt    = '0;
          end
        endcase
      end
    end
  end

  // result for the word being taken
  always_comb begin
    res_valid = 1'b0;
    res       = '0;
    res.kind       = K_VARINT;
    res.error_code = E_NONE;
    if (in_acc) begin
      if (is_end) begin
        if (!err_r) begin
          res_valid = 1'b1;
          if (phase_r != PH_KEY || idx_r != '0) begin
            res.kind       = K_ERROR;
            res.error_code = E_TRUNCATED;
            if (phase_r != PH_KEY) begin
              res.field_id = field_r;
              res.wtype    = wt_r;
            end
          end else begin
            res.kind = K_END;
          end
        end
      end else if (!err_r) begin
        case (phase_r)
          PH_KEY, PH_VARINT, PH_LENGTH: begin
            if (cont) begin
              if (too_long) begin
                res_valid      = 1'b1;
                res.kind       = K_ERROR;
                res.error_code = E_TOO_LONG;
                if (phase_r != PH_KEY) begin
                  res.field_id = field_r;
                  res.wtype    = wt_r;
                end
              end
            end else if (phase_r == PH_KEY) begin
              if (!wt_known) begin
                res_valid      = 1'b1;
                res.kind       = K_ERROR;
                res.error_code = E_WIRE_TYPE;
                res.field_id   = key_field;
                res.wtype      = key_wt;
              end
            end else begin
              res_valid    = 1'b1;
              res.field_id = field_r;
              res.wtype    = wt_r;
              if (phase_r == PH_VARINT) begin
                res.kind  = K_VARINT;
                res.value = vacc;
              end else if (len_big) begin
                res.kind       = K_ERROR;
                res.error_code = E_LEN_LARGE;
              end else begin
                res.kind  = K_LEN_HDR;
                res.value = vacc;
              end
            end
          end
          PH_FIXED64: begin
            if (idx_inc >= 4'(FIXED64_BYTES)) begin
              res_valid    = 1'b1;
              res.kind     = K_FIXED64;
              res.field_id = field_r;
              res.wtype    = wt_r;
              res.value    = f64acc;
            end
          end
          PH_FIXED32: begin
            if (idx_inc >= 4'(FIXED32_BYTES)) begin
              res_valid    = 1'b1;
              res.kind     = K_FIXED32;
              res.field_id = field_r;
              res.wtype    = wt_r;
            end
          end
          PH_PAYLOAD: begin
            if (emit_r) begin
              res_valid        = 1'b1;
              res.kind         = K_PAYLOAD;
              res.field_id     = field_r;
              res.wtype        = wt_r;
              res.payload_byte = b;
              res.payload_last = (bl_dec == '0);
            end
          end
          default: begin
            res_valid = 1'b0;
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_KEY;
      acc_r   <= '0;
      idx_r   <= '0;
      field_r <= '0;
      wt_r    <= '0;
      bl_r    <= '0;
      err_r   <= 1'b0;
      emit_r  <= 1'b1;
    end else begin
      phase_r <= phase_nxt;
      acc_r   <= acc_nxt;
      idx_r   <= idx_nxt;
      field_r <= field_nxt;
      wt_r    <= wt_nxt;
      bl_r    <= bl_nxt;
      err_r   <= err_nxt;
      if (cfg_valid && cfg_ready) begin
        emit_r <= cfg_data;
      end
    end
  end

  // output stage: result register plus one skid entry
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else if (skid_valid_r) begin
      if (out_take) begin
        skid_valid_r <= 1'b0;
      end
    end else if (res_valid) begin
      if (!out_valid_r || out_take) begin
        out_valid_r <= 1'b1;
      end else begin
        skid_valid_r <= 1'b1;
      end
    end else if (out_take) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (skid_valid_r) begin
      if (out_take) begin
        out_r <= skid_r;
      end
    end else if (res_valid) begin
      if (!out_valid_r || out_take) begin
        out_r <= res;
      end else begin
        skid_r <= res;
      end
    end
  end

  `PWP_ASSERT(a_skid_behind_out, skid_valid_r |-> out_valid_r, "skid full with result register empty")
  `PWP_ASSERT(a_end_resets, (in_acc && is_end) |=> (phase_r == PH_KEY && idx_r == '0 && !err_r), "end word did not reset parser")
  `PWP_ASSERT(a_err_idle, err_r |-> (phase_r == PH_KEY && idx_r == '0), "error latched mid-field")
  `PWP_NEVER(a_payload_len, phase_r == PH_PAYLOAD && bl_r == '0, "payload phase with no bytes left")

endmodule

`default_nettype wire

### tb/tb.sv
// Self-checking testbench for the protobuf wire parser: directed and random message streams.
`timescale 1ns / 100ps

module tb;
  import pwp_pkg::*;

  // Clock, reset and block ports. Every input starts at a known value.
  logic      clk       = 1'b0;
  logic      rst_n     = 1'b0;
  logic      in_valid  = 1'b0;
  logic      in_stall;
  in_word_t  in_data   = '0;
  logic      out_valid;
  logic      out_stall = 1'b0;
  out_word_t out_data;
  logic      cfg_valid = 1'b0;
  logic      cfg_ready;
  logic      cfg_data  = 1'b0;

  // Back-pressure hold-off: when it starts (in accepted words) and how long it lasts.
  localparam int HOLD_AT     = 120;
  localparam int HOLD_CYCLES = 150;

  protobuf_wire_parser dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data (out_data),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_data (cfg_data)
  );

  always #1 clk = ~clk;

  // ---------------------------------------------------------------------------
  // Stimulus store and expected decode results
  // ---------------------------------------------------------------------------
  in_word_t    pending_words[$];     // words waiting for the driver
  logic [7:0]  field_bytes[$];       // scratch: one encoded field before it is queued
  out_word_t   predicted_fields[$];  // decode results still owed by the block

  int words_queued = 0;
  int items_taken  = 0;
  int mismatches   = 0;
  int results_seen = 0;
  int cfg_writes   = 0;
  int backed_up_cycles = 0;
  int kind_count[8];
  int err_count[8];

  bit in_gaps_on  = 1'b0;  // sender idles at random
  bit out_gaps_on = 1'b0;  // receiver stalls at random

  // ---------------------------------------------------------------------------
  // Decoder state as the testbench sees it. Reset asserted once, so the
  // declaration values are the reset state. emit_on mirrors the register.
  // ---------------------------------------------------------------------------
  phase_t              exp_phase    = PH_KEY;
  logic [63:0]         vacc         = '0;   // varint / fixed64 under assembly
  int                  vbytes       = 0;    // bytes of the current value so far
  logic [31:0]         key_field    = '0;
  logic [2:0]          key_wt       = '0;
  logic [LEN_BITS-1:0] payload_left = '0;
  logic                in_error     = 1'b0; // swallowing bytes until end of message
  logic                emit_on      = 1'b1;

  function automatic void restart_field();
    exp_phase    = PH_KEY;
    vacc         = '0;
    vbytes       = 0;
    payload_left = '0;
  endfunction

  function automatic void push_field(kind_t k, logic [31:0] fld, logic [2:0] wt,
                                     logic [63:0] val, logic [7:0] pb, logic last,
                                     err_t ec);
    out_word_t w;
    w.kind         = k;
    w.field_id     = fld;
    w.wtype        = wt;
    w.value        = val;
    w.payload_byte = pb;
    w.payload_last = last;
    w.error_code   = ec;
    predicted_fields.push_back(w);
  endfunction

  // Errors found while still reading a key report field 0, wire type 0.
  function automatic void raise_error(err_t ec, logic key_err);
    in_error = 1'b1;
    restart_field();
    push_field(K_ERROR, key_err ? 32'd0 : key_field, key_err ? 3'd0 : key_wt,
               '0, '0, 1'b0, ec);
  endfunction

  // Advance the expected decoder by one accepted word.
  function automatic void parse_word(in_word_t w);
    logic [63:0] v;
    logic [7:0]  b;
    logic        mid, at_key, last;
    b = w.data_byte;
    if (w.operation) begin
      // End of message: truncated if we stopped inside a field, silent after an error.
      mid    = (exp_phase != PH_KEY) || (vbytes != 0);
      at_key = (exp_phase == PH_KEY);
      if (!in_error) begin
        if (mid)
          push_field(K_ERROR, at_key ? 32'd0 : key_field, at_key ? 3'd0 : key_wt,
                     '0, '0, 1'b0, E_TRUNCATED);
        else
          push_field(K_END, '0, '0, '0, '0, 1'b0, E_NONE);
      end
      in_error  = 1'b0;
      restart_field();
      key_field = '0;
      key_wt    = '0;
      return;
    end
    if (in_error) return;
    case (exp_phase)
      PH_KEY, PH_VARINT, PH_LENGTH: begin
        vacc |= 64'(b[6:0]) << (7 * vbytes);  // bits past 63 fall off
        if (b[7]) begin
          vbytes++;
          if (vbytes >= MAX_VARINT_BYTES) raise_error(E_TOO_LONG, exp_phase == PH_KEY);
          return;
        end
        v      = vacc;
        vacc   = '0;
        vbytes = 0;
        if (exp_phase == PH_KEY) begin
          key_field = v[34:3];
          key_wt    = v[2:0];
          case (key_wt)
            WT_VARINT:  exp_phase = PH_VARINT;
            WT_FIXED64: exp_phase = PH_FIXED64;
            WT_LEN:     exp_phase = PH_LENGTH;
            WT_FIXED32: exp_phase = PH_FIXED32;
            default:    raise_error(E_WIRE_TYPE, 1'b0);
          endcase
        end else if (exp_phase == PH_VARINT) begin
          exp_phase = PH_KEY;
          push_field(K_VARINT, key_field, key_wt, v, '0, 1'b0, E_NONE);
        end else if ((v >> LEN_BITS) != 0) begin
          raise_error(E_LEN_LARGE, 1'b0);
        end else begin
          payload_left = v[LEN_BITS-1:0];
          exp_phase    = (v == 0) ? PH_KEY : PH_PAYLOAD;
          push_field(K_LEN_HDR, key_field, key_wt, v, '0, 1'b0, E_NONE);
        end
      end
      PH_FIXED64: begin
        vacc |= 64'(b) << (8 * vbytes);  // little-endian
        vbytes++;
        if (vbytes >= FIXED64_BYTES) begin
          v = vacc;
          restart_field();
          push_field(K_FIXED64, key_field, key_wt, v, '0, 1'b0, E_NONE);
        end
      end
      PH_FIXED32: begin
        vbytes++;
        if (vbytes >= FIXED32_BYTES) begin
          restart_field();
          push_field(K_FIXED32, key_field, key_wt, '0, '0, 1'b0, E_NONE);
        end
      end
      PH_PAYLOAD: begin
        if (payload_left != 0) payload_left = payload_left - 1'b1;
        last = (payload_left == 0);
        if (last) restart_field();
        if (emit_on) push_field(K_PAYLOAD, key_field, key_wt, '0, b, last, E_NONE);
      end
      default: restart_field();
    endcase
  endfunction

  // ---------------------------------------------------------------------------
  // Message generation
  // ---------------------------------------------------------------------------
  function automatic int pick_gap();
    int r = $urandom_range(0, 99);
    if (r < 70) return 0;
    if (r < 95) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic int pick_pad();
    return ($urandom_range(0, 9) == 0) ? $urandom_range(1, 3) : 0;
  endfunction

  function automatic logic [2:0] pick_wt();
    int r = $urandom_range(0, 99);
    if (r < 30) return WT_VARINT;
    if (r < 45) return WT_FIXED64;
    if (r < 80) return WT_LEN;
    return WT_FIXED32;
  endfunction

  function automatic logic [63:0] pick_value();
    int r = $urandom_range(0, 9);
    if (r == 0) return '0;
    if (r == 1) return '1;
    return {$urandom, $urandom} >> $urandom_range(0, 63);
  endfunction

  function automatic int pick_len();
    int r = $urandom_range(0, 99);
    if (r < 15) return 0;
    if (r < 85) return $urandom_range(1, 6);
    return $urandom_range(7, 24);
  endfunction

  function automatic void queue_byte(logic [7:0] b);
    in_word_t w;
    w.operation = 1'b0;
    w.data_byte = b;
    pending_words.push_back(w);
    words_queued++;
  endfunction

  // The byte lane is don't-care on an end mark; fill it with noise.
  function automatic void queue_end();
    in_word_t w;
    w.operation = 1'b1;
    w.data_byte = 8'($urandom);
    pending_words.push_back(w);
    words_queued++;
  endfunction

  function automatic void queue_noise(int n);
    repeat (n) queue_byte(8'($urandom));
  endfunction

  // LEB128, optionally padded with redundant continuation bytes (never past ten).
  function automatic void add_varint(logic [63:0] v, int pad);
    logic [63:0] r;
    int          n, total;
    n = 1;
    r = v >> 7;
    while (r != 0) begin
      n++;
      r = r >> 7;
    end
    total = (n + pad > MAX_VARINT_BYTES) ? MAX_VARINT_BYTES : n + pad;
    for (int i = 0; i < total; i++) begin
      field_bytes.push_back({1'(i < total - 1), v[6:0]});
      v = v >> 7;
    end
  endfunction

  // Field numbers: mostly small, some wide, some all ones, some keys above 35 bits.
  function automatic void add_key(logic [2:0] wt);
    logic [63:0] key;
    int          r;
    r   = $urandom_range(0, 9);
    key = '0;
    if (r < 5)      key[34:3] = 32'($urandom_range(0, 15));
    else if (r < 8) key[34:3] = $urandom >> $urandom_range(0, 31);
    else if (r < 9) key[34:3] = '1;
    else            key = {$urandom, $urandom};
    key[2:0] = wt;
    add_varint(key, pick_pad());
  endfunction

  function automatic void build_field(logic [2:0] wt);
    int len;
    add_key(wt);
    case (wt)
      WT_VARINT:  add_varint(pick_value(), pick_pad());
      WT_FIXED64: repeat (FIXED64_BYTES) field_bytes.push_back(8'($urandom));
      WT_LEN: begin
        len = pick_len();
        add_varint(64'(len), pick_pad());
        repeat (len) field_bytes.push_back(8'($urandom));
      end
      WT_FIXED32: repeat (FIXED32_BYTES) field_bytes.push_back(8'($urandom));
      default: ;  // unknown wire types: key only
    endcase
  endfunction

  function automatic void commit_bytes(int keep);
    for (int i = 0; i < keep && i < field_bytes.size(); i++) queue_byte(field_bytes[i]);
    field_bytes.delete();
  endfunction

  // One message: some good fields, then (30 % of the time) a broken tail, then the end mark.
  function automatic void queue_message();
    logic [63:0] big;
    logic [2:0]  bad_wt[4];
    int          nf, r;
    bad_wt = '{3'd3, 3'd4, 3'd6, 3'd7};
    nf = $urandom_range(0, 5);
    r  = $urandom_range(0, 99);
    repeat (nf) begin
      build_field(pick_wt());
      commit_bytes(field_bytes.size());
    end
    if (r >= 70 && r < 78) begin
      // cut short somewhere inside a field
      build_field(pick_wt());
      commit_bytes($urandom_range(1, field_bytes.size() - 1));
    end else if (r >= 78 && r < 84) begin
      build_field(bad_wt[$urandom_range(0, 3)]);
      commit_bytes(field_bytes.size());
      queue_noise($urandom_range(0, 3));
    end else if (r >= 84 && r < 89) begin
      // over-long varint, either as the key or as the value
      if ($urandom_range(0, 1)) add_key($urandom_range(0, 1) ? WT_VARINT : WT_LEN);
      repeat (MAX_VARINT_BYTES) field_bytes.push_back({1'b1, 7'($urandom)});
      commit_bytes(field_bytes.size());
      queue_noise($urandom_range(0, 3));
    end else if (r >= 89 && r < 94) begin
      big = {$urandom, $urandom};
      big[32 + $urandom_range(0, 31)] = 1'b1;
      add_key(WT_LEN);
      add_varint(big, 0);
      commit_bytes(field_bytes.size());
      queue_noise($urandom_range(0, 3));
    end else if (r >= 94) begin
      queue_noise($urandom_range(1, 8));
    end
    queue_end();
  endfunction

  // ---------------------------------------------------------------------------
  // Driver: presents queued words, holds a stalled word steady, and feeds
  // each accepted word to the expected decoder on the edge it is taken.
  // ---------------------------------------------------------------------------
  int send_gap = 0;

  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
      send_gap <= 0;
    end else begin
      if (in_valid && !in_stall) begin
        parse_word(in_data);
        items_taken++;
      end
      if (!in_valid || !in_stall) begin
        if (send_gap != 0) begin
          in_valid <= 1'b0;
          send_gap <= send_gap - 1;
        end else if (pending_words.size() != 0) begin
          in_data  <= pending_words.pop_front();
          in_valid <= 1'b1;
          send_gap <= in_gaps_on ? pick_gap() : 0;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Hold-off: once, after HOLD_AT words, the receiver stalls for a long
  // stretch while the sender keeps going, so the output stage fills and
  // in_stall has to rise.
  // ---------------------------------------------------------------------------
  int hold_left = 0;
  bit hold_done = 1'b0;

  always @(posedge clk) begin
    if (!rst_n) begin
      hold_left <= 0;
      hold_done <= 1'b0;
    end else if (!hold_done && items_taken >= HOLD_AT) begin
      hold_left <= HOLD_CYCLES;
      hold_done <= 1'b1;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
      if (in_stall) backed_up_cycles++;
    end
  end

  // ---------------------------------------------------------------------------
  // Monitor: takes each result word and checks it against the oldest
  // expectation; also drives random receiver stalls.
  // ---------------------------------------------------------------------------
  int stall_left = 0;

  function automatic string describe_field(out_word_t w);
    return $sformatf("kind %0d fld %0h wt %0d val %0h pb %0h last %0b err %0d",
                     w.kind, w.field_id, w.wtype, w.value, w.payload_byte,
                     w.payload_last, w.error_code);
  endfunction

  always @(posedge clk) begin
    out_word_t want;
    if (!rst_n) begin
      out_stall  <= 1'b0;
      stall_left <= 0;
    end else begin
      if (out_valid && !out_stall) begin
        results_seen++;
        kind_count[out_data.kind]++;
        if (out_data.kind == K_ERROR) err_count[out_data.error_code]++;
        if (predicted_fields.size() == 0) begin
          if (mismatches < 10)
            $display("%0t: unexpected result word: %s", $time, describe_field(out_data));
          mismatches++;
        end else begin
          want = predicted_fields.pop_front();
          if (want.kind !== out_data.kind || want.field_id !== out_data.field_id ||
              want.wtype !== out_data.wtype || want.value !== out_data.value ||
              want.payload_byte !== out_data.payload_byte ||
              want.payload_last !== out_data.payload_last ||
              want.error_code !== out_data.error_code) begin
            if (mismatches < 10) begin
              $display("%0t: result mismatch", $time);
              $display("  expected %s", describe_field(want));
              $display("  actual   %s", describe_field(out_data));
            end
            mismatches++;
          end
        end
      end
      if (hold_left != 0) begin
        out_stall <= 1'b1;
      end else if (stall_left != 0) begin
        out_stall  <= 1'b1;
        stall_left <= stall_left - 1;
      end else begin
        out_stall <= 1'b0;
        if (out_gaps_on && $urandom_range(0, 3) == 0) stall_left <= pick_gap();
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Sequencing
  // ---------------------------------------------------------------------------

  // Idle means: nothing queued or offered, nothing owed. The short pause then
  // covers words (key bytes, dropped payload) that are still in flight with
  // no result to show for it.
  task automatic settle_parser();
    do @(negedge clk);
    while (pending_words.size() != 0 || in_valid || predicted_fields.size() != 0);
    repeat (4) @(posedge clk);
  endtask

  task automatic set_emit(input logic val);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_data  <= val;
    do @(posedge clk);
    while (!cfg_ready);
    cfg_valid <= 1'b0;
    emit_on = val;
    cfg_writes++;
  endtask

  task automatic queue_random(int n);
    int target;
    target = words_queued + n;
    while (words_queued < target) queue_message();
  endtask

  initial begin
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    // Directed opener, payload passing on (reset value of the register).
    queue_end();                                                  // empty message
    queue_byte(8'h0D); queue_byte(8'h00); queue_byte(8'hFF);      // fixed32, field 1
    queue_byte(8'h10); queue_byte(8'h20);
    queue_byte(8'h12); queue_byte(8'h00);                         // zero-length field 2
    queue_byte(8'h1A); queue_byte(8'h01); queue_byte(8'hFF);      // one payload byte
    queue_end();
    queue_byte(8'h0B); queue_byte(8'h55); queue_end();            // wire type 3, swallowed
    queue_byte(8'h08); queue_byte(8'h96); queue_end();            // ends inside a varint
    queue_byte(8'h12); queue_byte(8'h80); queue_byte(8'h80);      // length 2^32
    queue_byte(8'h80); queue_byte(8'h80); queue_byte(8'h10); queue_end();
    queue_byte(8'h80); queue_end();                               // ends inside a key
    settle_parser();

    // Random phases: the register toggles between them, and the idling mix
    // changes so that some stretches run flat out on one side or both.
    in_gaps_on = 1'b1; out_gaps_on = 1'b1;
    queue_random(420);                       // hold-off lands in here
    settle_parser();

    set_emit(1'b0);
    in_gaps_on = 1'b0; out_gaps_on = 1'b1;
    queue_random(300);
    settle_parser();

    set_emit(1'b1);
    in_gaps_on = 1'b1; out_gaps_on = 1'b0;
    queue_random(280);
    settle_parser();

    set_emit(1'b0);
    in_gaps_on = 1'b1; out_gaps_on = 1'b1;
    queue_random(150);
    settle_parser();

    set_emit(1'b1);
    in_gaps_on = 1'b0; out_gaps_on = 1'b0;
    queue_random(100);
    settle_parser();
    repeat (8) @(posedge clk);

    $display("run: %0d words in, %0d results: varint %0d fixed64 %0d header %0d",
             items_taken, results_seen, kind_count[K_VARINT], kind_count[K_FIXED64],
             kind_count[K_LEN_HDR]);
    $display("  payload %0d fixed32 %0d end %0d; errors long/wt/trunc/len %0d/%0d/%0d/%0d;",
             kind_count[K_PAYLOAD], kind_count[K_FIXED32], kind_count[K_END],
             err_count[E_TOO_LONG], err_count[E_WIRE_TYPE], err_count[E_TRUNCATED],
             err_count[E_LEN_LARGE]);
    $display("  %0d register writes, input stalled %0d cycles under hold-off, %0d mismatches",
             cfg_writes, backed_up_cycles, mismatches);
    if (predicted_fields.size() != 0)
      $display("%0d expected results never arrived", predicted_fields.size());

    if (mismatches == 0 && predicted_fields.size() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

  // Watchdog, several times the slowest legal run.
  initial begin
    #1_000_000;
    $display("timeout: %0d words unsent, %0d results outstanding",
             pending_words.size(), predicted_fields.size());
    $display("[FAIL] regression broken");
    $finish;
  end

endmodule
